// ===== sv/lkvc_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared types, codes and defaults for the LRU key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

	// built size and register reset
	localparam int          CAPACITY_DEF = 16;
	localparam int          CFG_W        = 5;
	localparam logic [4:0]  CAP_RESET    = 5'd16;

	// operation codes
	localparam logic [1:0]  MODE_GET   = 2'd0;
	localparam logic [1:0]  MODE_SET   = 2'd1;
	localparam logic [1:0]  MODE_ERASE = 2'd2;

	// value returned when nothing is read
	localparam logic signed [31:0] NO_VALUE = 32'shFFFF_FFFF;

	typedef struct packed {
		logic [1:0]         mode;
		logic signed [31:0] lookup_key;
		logic signed [31:0] store_value;
	} in_word_t;

	typedef struct packed {
		logic               hit;
		logic signed [31:0] read_value;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FIND,
		ST_UPDATE,
		ST_COMMIT
	} state_t;

	// sequencer to store controls
	typedef struct packed {
		logic load;     // command word taken
		logic find_rd;  // find pass read issued
		logic upd_rd;   // rank update pass read issued
		logic commit;   // final write-back cycle
	} ctrl_t;

endpackage
`default_nettype wire

// ===== sv/lkvc_seq.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_seq
// Sequencer: runs the find pass, the rank update pass and the commit cycle,
// and steps the shared entry address.
// ----------------------------------------------------------------------------
module lkvc_seq #(
	parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  wire                                      start,
	output logic                                     busy,
	output lkvc_pkg::ctrl_t                          ctrl,
	output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] addr
);

	localparam int            IW   = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam logic [IW-1:0] LAST = IW'(CAPACITY - 1);

	lkvc_pkg::state_t state_q, state_d;
	logic [IW-1:0]    addr_q, addr_d;

	// state and address registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lkvc_pkg::ST_IDLE;
			addr_q  <= '0;
		end else begin
			state_q <= state_d;
			addr_q  <= addr_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d      = state_q;
		addr_d       = addr_q;
		ctrl         = '0;
		busy         = 1'b1;
		case (state_q)
			lkvc_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					ctrl.load = 1'b1;
					addr_d    = '0;
					state_d   = lkvc_pkg::ST_FIND;
				end
			end
			lkvc_pkg::ST_FIND: begin
				ctrl.find_rd = 1'b1;
				if (addr_q == LAST) begin
					addr_d  = '0;
					state_d = lkvc_pkg::ST_UPDATE;
				end else begin
					addr_d = addr_q + IW'(1);
				end
			end
			lkvc_pkg::ST_UPDATE: begin
				ctrl.upd_rd = 1'b1;
				if (addr_q == LAST) begin
					addr_d  = '0;
					state_d = lkvc_pkg::ST_COMMIT;
				end else begin
					addr_d = addr_q + IW'(1);
				end
			end
			lkvc_pkg::ST_COMMIT: begin
				ctrl.commit = 1'b1;
				state_d     = lkvc_pkg::ST_IDLE;
			end
			default: begin
				state_d = lkvc_pkg::ST_IDLE;
			end
		endcase
	end

	assign addr = addr_q;

endmodule
`default_nettype wire

// ===== sv/lkvc_store.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lkvc_store
// Entry memories, valid bits and the shared scan unit: one entry a cycle is
// compared for key match, oldest entry and first free slot, then a second
// pass rewrites the recency ranks, and a commit cycle stores the word.
// ----------------------------------------------------------------------------
module lkvc_store #(
	parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
	input  wire                                      clk,
	input  wire                                      arst_n,
	input  lkvc_pkg::ctrl_t                          ctrl,
	input  wire [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] addr,
	input  lkvc_pkg::in_word_t                       cmd,
	input  wire [lkvc_pkg::CFG_W-1:0]                capacity,
	output logic                                     done,
	output lkvc_pkg::out_word_t                      rsp
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int RW = IW;
	localparam int OW = $clog2(CAPACITY + 1);
	localparam int LW = (OW > lkvc_pkg::CFG_W) ? OW : lkvc_pkg::CFG_W;

	// entry storage
	logic signed [31:0] key_mem   [CAPACITY];
	logic signed [31:0] value_mem [CAPACITY];
	logic [RW-1:0]      rank_mem  [CAPACITY];
	logic [CAPACITY-1:0] valid_q;
	logic [OW-1:0]       occ_q;

	// captured command
	logic [1:0]         mode_q;
	logic signed [31:0] key_q;
	logic signed [31:0] val_q;

	// read pipeline
	logic               find_v_s1, upd_v_s1;
	logic [IW-1:0]      addr_s1;
	logic signed [31:0] key_rd_s1, val_rd_s1;
	logic [RW-1:0]      rank_rd_s1;

	// find pass results
	logic               found_q, vic_found_q, free_found_q;
	logic [IW-1:0]      idx_q, vic_q, free_q;
	logic [RW-1:0]      mrank_q, vrank_q;
	logic signed [31:0] mval_q;

	// result
	logic                done_q;
	lkvc_pkg::out_word_t rsp_q;

	// effective capacity, saturated to the built size
	logic [LW-1:0] cap_ext, cap_lim;
	logic          cap_on;
	assign cap_ext = LW'(capacity);
	assign cap_lim = (cap_ext > LW'(CAPACITY)) ? LW'(CAPACITY) : cap_ext;
	assign cap_on  = (cap_lim != '0);

	// operation decode from the find pass
	logic is_get, is_set, is_erase;
	logic do_touch, do_remove, do_insert, evict;
	logic [IW-1:0] slot;
	assign is_get    = (mode_q == lkvc_pkg::MODE_GET);
	assign is_set    = (mode_q == lkvc_pkg::MODE_SET);
	assign is_erase  = (mode_q == lkvc_pkg::MODE_ERASE);
	assign do_touch  = found_q && (is_get || (is_set && cap_on));
	assign do_remove = found_q && is_erase;
	assign do_insert = !found_q && is_set && cap_on;
	assign evict     = do_insert && (LW'(occ_q) >= cap_lim);
	assign slot      = (evict && (!free_found_q || (vic_q < free_q))) ? vic_q : free_q;

	// memory reads, one address a cycle
	always_ff @(posedge clk) begin
		key_rd_s1  <= key_mem[addr];
		val_rd_s1  <= value_mem[addr];
		rank_rd_s1 <= rank_mem[addr];
		addr_s1    <= addr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			find_v_s1 <= 1'b0;
			upd_v_s1  <= 1'b0;
		end else begin
			find_v_s1 <= ctrl.find_rd;
			upd_v_s1  <= ctrl.upd_rd;
		end
	end

	// command capture
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			mode_q <= cmd.mode;
			key_q  <= cmd.lookup_key;
			val_q  <= cmd.store_value;
		end
	end

	// scan unit: key match, oldest valid entry, first free slot
	logic cur_v;
	assign cur_v = valid_q[addr_s1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (ctrl.load) begin
			found_q      <= 1'b0;
			vic_found_q  <= 1'b0;
			free_found_q <= 1'b0;
		end else if (find_v_s1) begin
			if (cur_v && (key_rd_s1 == key_q) && !found_q) begin
				found_q <= 1'b1;
			end
			if (cur_v && (!vic_found_q || (rank_rd_s1 > vrank_q))) begin
				vic_found_q <= 1'b1;
			end
			if (!cur_v && !free_found_q) begin
				free_found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (find_v_s1) begin
			if (cur_v && (key_rd_s1 == key_q) && !found_q) begin
				idx_q   <= addr_s1;
				mrank_q <= rank_rd_s1;
				mval_q  <= val_rd_s1;
			end
			if (cur_v && (!vic_found_q || (rank_rd_s1 > vrank_q))) begin
				vic_q   <= addr_s1;
				vrank_q <= rank_rd_s1;
			end
			if (!cur_v && !free_found_q) begin
				free_q <= addr_s1;
			end
		end
	end

	// rank update for the entry read in the previous cycle
	logic [RW-1:0] rank_new;
	always_comb begin
		rank_new = rank_rd_s1;
		if (do_touch) begin
			if (addr_s1 == idx_q) begin
				rank_new = '0;
			end else if (cur_v && (rank_rd_s1 < mrank_q)) begin
				rank_new = rank_rd_s1 + RW'(1);
			end
		end else if (do_remove) begin
			if (cur_v && (rank_rd_s1 > mrank_q)) begin
				rank_new = rank_rd_s1 - RW'(1);
			end
		end else if (do_insert) begin
			if (addr_s1 == slot) begin
				rank_new = '0;
			end else if (cur_v && !(evict && (addr_s1 == vic_q))) begin
				rank_new = rank_rd_s1 + RW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (upd_v_s1) begin
			rank_mem[addr_s1] <= rank_new;
		end
	end

	// commit: key and value writes
	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			if (do_touch && is_set) begin
				value_mem[idx_q] <= val_q;
			end else if (do_insert) begin
				key_mem[slot]   <= key_q;
				value_mem[slot] <= val_q;
			end
		end
	end

	// commit: valid bits and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			occ_q   <= '0;
		end else if (ctrl.commit) begin
			if (do_remove) begin
				valid_q[idx_q] <= 1'b0;
				occ_q          <= occ_q - OW'(1);
			end else if (do_insert) begin
				if (evict) begin
					valid_q[vic_q] <= 1'b0;
				end
				valid_q[slot] <= 1'b1;
				if (!evict) begin
					occ_q <= occ_q + OW'(1);
				end
			end
		end
	end

	// result word, shown for one cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctrl.commit;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.commit) begin
			rsp_q.hit        <= found_q;
			rsp_q.read_value <= (is_get && found_q) ? mval_q : lkvc_pkg::NO_VALUE;
		end
	end

	assign done = done_q;
	assign rsp  = rsp_q;

	// occupancy tracks the valid bits
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(occ_q))
		else $error("occupancy does not match valid entries");

	// a result word only follows a commit
	a_done_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(ctrl.commit))
		else $error("result strobe without commit");

	// an insert always finds a slot
	a_insert_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.commit && do_insert) |-> (evict || free_found_q))
		else $error("insert without a free slot");

	// a matched entry ranks inside the occupied range
	a_match_rank: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.commit && found_q) |-> (OW'(mrank_q) < occ_q))
		else $error("matched entry rank out of range");

endmodule
`default_nettype wire

// ===== sv/lru_key_value_cache.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_key_value_cache
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Pulse start with a command word while busy is low. No new command is
// taken while busy is high: one memory read port walks all entries twice,
// once to match the key and find the oldest entry and a free slot, once to
// rewrite the recency ranks, and then a commit cycle follows. The result
// word appears for exactly one cycle with done high, in the cycle busy
// drops; there is no way to hold it off, so capture it then. The store is
// empty right after reset with no clearing pass. Write cfg_data with cfg_we
// only while idle; values above CAPACITY act as CAPACITY.
// ----------------------------------------------------------------------------
module lru_key_value_cache #(
	parameter int CAPACITY = lkvc_pkg::CAPACITY_DEF
) (
	input  wire                       clk,
	input  wire                       arst_n,
	input  wire                       start,
	output logic                      busy,
	input  lkvc_pkg::in_word_t        cmd,
	output logic                      done,
	output lkvc_pkg::out_word_t       rsp,
	input  wire                       cfg_we,
	input  wire [lkvc_pkg::CFG_W-1:0] cfg_data
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

	lkvc_pkg::ctrl_t            ctrl;
	logic [IW-1:0]              addr;
	logic [lkvc_pkg::CFG_W-1:0] capacity_q;

	// capacity register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			capacity_q <= lkvc_pkg::CAP_RESET;
		end else if (cfg_we) begin
			capacity_q <= cfg_data;
		end
	end

	lkvc_seq #(
		.CAPACITY (CAPACITY)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl),
		.addr   (addr)
	);

	lkvc_store #(
		.CAPACITY (CAPACITY)
	) u_store (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (ctrl),
		.addr     (addr),
		.cmd      (cmd),
		.capacity (capacity_q),
		.done     (done),
		.rsp      (rsp)
	);

endmodule
`default_nettype wire

// ===== tb/tb_lru_key_value_cache.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_key_value_cache
// Self-checking bench for the LRU key-value cache. Get, set, erase and no-op
// words are sent through the start/busy handshake and an in-bench LRU model
// predicts each response. A directed pass covers the key and value extremes,
// updates, erases, eviction order, capacity zero, saturation and shrinking.
// Random traffic over a small key pool then runs under several capacities
// and sender idle rates. Every response is checked field by field in order.
// ----------------------------------------------------------------------------
module tb_lru_key_value_cache;

	localparam int          CAP_N          = lkvc_pkg::CAPACITY_DEF;
	localparam logic [1:0]  MODE_NOP       = 2'd3;
	localparam int          KEY_POOL_N     = 24;
	localparam int          WATCHDOG_LIMIT = 2000;
	localparam int          TAIL_CYCLES    = 2 * CAP_N + 8;
	localparam logic [31:0] KEY_MIN        = 32'h8000_0000;
	localparam logic [31:0] KEY_MAX        = 32'h7FFF_FFFF;

	logic                       clk = 1'b0;
	logic                       arst_n;
	logic                       start;
	logic                       busy;
	lkvc_pkg::in_word_t         cmd;
	logic                       done;
	lkvc_pkg::out_word_t        rsp;
	logic                       cfg_we;
	logic [lkvc_pkg::CFG_W-1:0] cfg_data;

	// cache model state
	logic        lru_valid [CAP_N];
	logic [31:0] lru_key   [CAP_N];
	logic [31:0] lru_value [CAP_N];
	int          lru_rank  [CAP_N];
	int          lru_count;
	int          cap_setting;

	lkvc_pkg::out_word_t expected_rsp_q[$];
	logic [31:0]         key_pool [KEY_POOL_N];
	int                  sender_idle_pct;
	int                  error_count;
	int                  quiet_cycles;

	lru_key_value_cache #(.CAPACITY(CAP_N)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.busy     (busy),
		.cmd      (cmd),
		.done     (done),
		.rsp      (rsp),
		.cfg_we   (cfg_we),
		.cfg_data (cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// LRU model
	// ------------------------------------------------------------------
	function automatic int lru_find(logic [31:0] k);
		for (int i = 0; i < CAP_N; i++)
			if (lru_valid[i] && lru_key[i] == k)
				return i;
		return -1;
	endfunction

	// entry becomes most recent, newer entries age by one
	function automatic void lru_touch(int idx);
		int r;
		r = lru_rank[idx];
		for (int i = 0; i < CAP_N; i++)
			if (lru_valid[i] && lru_rank[i] < r)
				lru_rank[i]++;
		lru_rank[idx] = 0;
	endfunction

	// entry leaves, older entries move up by one
	function automatic void lru_drop(int idx);
		int r;
		r = lru_rank[idx];
		lru_valid[idx] = 1'b0;
		for (int i = 0; i < CAP_N; i++)
			if (lru_valid[i] && lru_rank[i] > r)
				lru_rank[i]--;
		if (lru_count > 0)
			lru_count--;
	endfunction

	function automatic void lru_insert(logic [31:0] k, logic [31:0] v, int cap);
		int slot;
		int victim;
		slot   = -1;
		victim = -1;
		if (lru_count >= cap) begin
			for (int i = 0; i < CAP_N; i++)
				if (lru_valid[i] && (victim < 0 || lru_rank[i] > lru_rank[victim]))
					victim = i;
			if (victim >= 0)
				lru_drop(victim);
		end
		for (int i = 0; i < CAP_N; i++) begin
			if (lru_valid[i])
				lru_rank[i]++;
			else if (slot < 0)
				slot = i;
		end
		if (slot < 0)
			return;
		lru_valid[slot] = 1'b1;
		lru_key[slot]   = k;
		lru_value[slot] = v;
		lru_rank[slot]  = 0;
		lru_count++;
	endfunction

	// response for one command word, state updated as the cache would
	function automatic lkvc_pkg::out_word_t lru_apply(lkvc_pkg::in_word_t w);
		lkvc_pkg::out_word_t r;
		int                  idx;
		int                  cap;
		cap = (cap_setting > CAP_N) ? CAP_N : cap_setting;
		idx = lru_find(w.lookup_key);
		r.hit        = (idx >= 0);
		r.read_value = lkvc_pkg::NO_VALUE;
		case (w.mode)
			lkvc_pkg::MODE_GET: begin
				if (idx >= 0) begin
					r.read_value = lru_value[idx];
					lru_touch(idx);
				end
			end
			lkvc_pkg::MODE_SET: begin
				if (cap != 0) begin
					if (idx >= 0) begin
						lru_value[idx] = w.store_value;
						lru_touch(idx);
					end else begin
						lru_insert(w.lookup_key, w.store_value, cap);
					end
				end
			end
			lkvc_pkg::MODE_ERASE: begin
				if (idx >= 0)
					lru_drop(idx);
			end
			default: ;
		endcase
		return r;
	endfunction

	// ------------------------------------------------------------------
	// response checker
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$error("response word with none expected: hit %0b read_value %0d",
					rsp.hit, rsp.read_value);
				error_count++;
			end else begin
				lkvc_pkg::out_word_t want;
				want = expected_rsp_q.pop_front();
				if (rsp.hit !== want.hit) begin
					$error("hit: expected %0b, actual %0b", want.hit, rsp.hit);
					error_count++;
				end
				if (rsp.read_value !== want.read_value) begin
					$error("read_value: expected %0d, actual %0d",
						want.read_value, rsp.read_value);
					error_count++;
				end
			end
		end
	end

	// watchdog on cycles with no word moving either way
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done)
				quiet_cycles = 0;
			else
				quiet_cycles++;
			if (quiet_cycles >= WATCHDOG_LIMIT) begin
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// ------------------------------------------------------------------
	// driver tasks
	// ------------------------------------------------------------------
	task automatic send_word(input logic [1:0] m, input logic [31:0] k,
			input logic [31:0] v);
		lkvc_pkg::in_word_t w;
		int                 gap;
		w.mode        = m;
		w.lookup_key  = k;
		w.store_value = v;
		gap = ($urandom_range(99) < sender_idle_pct) ? $urandom_range(1, 6) : 0;
		repeat (gap) @(negedge clk);
		@(negedge clk);
		start <= 1'b1;
		cmd   <= w;
		// taken at the first rising edge with busy low
		do @(posedge clk); while (busy);
		expected_rsp_q.push_back(lru_apply(w));
		@(negedge clk);
		start <= 1'b0;
	endtask

	task automatic wait_drain();
		while (expected_rsp_q.size() != 0)
			@(posedge clk);
	endtask

	// register write only while idle
	task automatic write_capacity(input int v);
		wait_drain();
		repeat (2) @(negedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v[lkvc_pkg::CFG_W-1:0];
		@(negedge clk);
		cfg_we <= 1'b0;
		cap_setting = v;
	endtask

	// ------------------------------------------------------------------
	// tests
	// ------------------------------------------------------------------
	task automatic test_basic_ops();
		sender_idle_pct = 0;
		send_word(lkvc_pkg::MODE_GET,   KEY_MIN,       32'h0);
		send_word(lkvc_pkg::MODE_SET,   KEY_MIN,       KEY_MAX);
		send_word(lkvc_pkg::MODE_SET,   KEY_MAX,       KEY_MIN);
		send_word(lkvc_pkg::MODE_SET,   32'h0,         32'h0);
		send_word(lkvc_pkg::MODE_SET,   32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_word(lkvc_pkg::MODE_GET,   KEY_MIN,       32'h0);
		send_word(lkvc_pkg::MODE_GET,   KEY_MAX,       32'hFFFF_FFFF);
		// update in place
		send_word(lkvc_pkg::MODE_SET,   KEY_MAX,       32'd12345);
		send_word(lkvc_pkg::MODE_GET,   KEY_MAX,       32'h0);
		// erase present, then absent
		send_word(lkvc_pkg::MODE_ERASE, 32'h0,         32'h0);
		send_word(lkvc_pkg::MODE_ERASE, 32'h0,         32'h0);
		send_word(lkvc_pkg::MODE_GET,   32'h0,         32'h0);
		// no-op reports presence only
		send_word(MODE_NOP,             KEY_MIN,       32'h5A5A_5A5A);
		send_word(MODE_NOP,             32'h0,         32'h0);
	endtask

	// capacity dropped below occupancy: each insert evicts one
	task automatic test_eviction_order();
		write_capacity(2);
		send_word(lkvc_pkg::MODE_SET, 32'd7, 32'd70);
		send_word(lkvc_pkg::MODE_GET, KEY_MIN, 32'h0);
		send_word(lkvc_pkg::MODE_SET, 32'd8, 32'd80);
		send_word(lkvc_pkg::MODE_GET, 32'hFFFF_FFFF, 32'h0);
	endtask

	// capacity zero: sets do nothing, hit still reported
	task automatic test_capacity_zero();
		write_capacity(0);
		send_word(lkvc_pkg::MODE_SET, 32'd9, 32'd90);
		send_word(lkvc_pkg::MODE_SET, 32'd8, 32'd88);
		send_word(lkvc_pkg::MODE_GET, 32'd8, 32'h0);
		send_word(lkvc_pkg::MODE_GET, 32'd9, 32'h0);
	endtask

	task automatic test_capacity_saturate();
		write_capacity(31);
		send_word(lkvc_pkg::MODE_SET, 32'd10, 32'd100);
		send_word(lkvc_pkg::MODE_GET, 32'd10, 32'h0);
	endtask

	task automatic run_random_phase(input int cap, input int idle_pct, input int n_items);
		int          pick;
		logic [1:0]  m;
		logic [31:0] k;
		write_capacity(cap);
		sender_idle_pct = idle_pct;
		for (int i = 0; i < n_items; i++) begin
			pick = $urandom_range(99);
			if (pick < 40)
				m = lkvc_pkg::MODE_GET;
			else if (pick < 80)
				m = lkvc_pkg::MODE_SET;
			else if (pick < 95)
				m = lkvc_pkg::MODE_ERASE;
			else
				m = MODE_NOP;
			if ($urandom_range(9) == 0)
				k = $urandom;
			else
				k = key_pool[$urandom_range(KEY_POOL_N - 1)];
			// sender holds off until the cache has answered everything
			if ($urandom_range(19) == 0)
				wait_drain();
			send_word(m, k, $urandom);
		end
	endtask

	task automatic test_random_traffic();
		for (int i = 0; i < KEY_POOL_N; i++)
			key_pool[i] = $urandom;
		run_random_phase(16, 0,  80);
		run_random_phase(31, 51, 80);
		run_random_phase(3,  18, 60);
		run_random_phase(0,  0,  30);
		run_random_phase(1,  51, 40);
		run_random_phase(16, 18, 80);
		run_random_phase(8,  0,  70);
		run_random_phase(2,  51, 50);
	endtask

	// ------------------------------------------------------------------
	// main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n          = 1'b0;
		start           = 1'b0;
		cmd             = '0;
		cfg_we          = 1'b0;
		cfg_data        = '0;
		error_count     = 0;
		quiet_cycles    = 0;
		sender_idle_pct = 0;
		cap_setting     = int'(lkvc_pkg::CAP_RESET);
		lru_count       = 0;
		for (int i = 0; i < CAP_N; i++) begin
			lru_valid[i] = 1'b0;
			lru_key[i]   = '0;
			lru_value[i] = '0;
			lru_rank[i]  = 0;
		end
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_basic_ops();
		test_eviction_order();
		test_capacity_zero();
		test_capacity_saturate();
		test_random_traffic();

		wait_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_rsp_q.size() != 0) begin
			$error("%0d expected response words never came", expected_rsp_q.size());
			error_count++;
		end
		if (error_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
